// ===== src/matmul_bias_activation_macros.svh =====
// Assertion macros used by the matmul_bias_activation module.
`ifndef MATMUL_BIAS_ACTIVATION_MACROS_SVH
`define MATMUL_BIAS_ACTIVATION_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define MBA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define MBA_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== src/mba_pkg.sv =====
// ----------------------------------------------------------------------------
// mba_pkg
// Types, constants and the tanh table of the fused matrix multiply block.
// ----------------------------------------------------------------------------
package mba_pkg;
	localparam int MaxRows = 16;
	localparam int MaxCols = 16;
	localparam int MaxDepth = 16;
	localparam int DataWidth = 16;

	typedef enum logic [1:0] {
		KIND_WR_A    = 2'd0,
		KIND_WR_B    = 2'd1,
		KIND_WR_BIAS = 2'd2,
		KIND_QUERY   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_M_ROWS   = 2'd0,
		REG_N_COLS   = 2'd1,
		REG_K_DEPTH  = 2'd2,
		REG_ACT_MODE = 2'd3
	} reg_idx_t;

	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_RELU = 2'd1;
	localparam logic [1:0] ACT_GELU = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BIAS,
		ST_MAC,
		ST_ROUND,
		ST_SQ,
		ST_CUBE,
		ST_INNER,
		ST_U,
		ST_TANH,
		ST_OUT,
		ST_SAT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [3:0]        row_index;
		logic [3:0]        col_index;
		logic signed [15:0] elem_value;
	} in_item_t;

	typedef struct packed {
		logic [3:0]        out_row;
		logic [3:0]        out_col;
		logic signed [15:0] out_value;
		logic              saturated;
		logic              range_error;
	} out_item_t;

	typedef struct packed {
		logic [5:0]  cfg_index;
		logic [31:0] cfg_value;
	} cfg_item_t;

	function automatic logic [11:0] tanh_tab(input logic [4:0] i);
		case (i)
			5'd0: return 12'd0;
			5'd1: return 12'd1003;
			5'd2: return 12'd1893;
			5'd3: return 12'd2602;
			5'd4: return 12'd3119;
			5'd5: return 12'd3475;
			5'd6: return 12'd3707;
			5'd7: return 12'd3856;
			5'd8: return 12'd3949;
			5'd9: return 12'd4006;
			5'd10: return 12'd4041;
			5'd11: return 12'd4062;
			5'd12: return 12'd4076;
			5'd13: return 12'd4084;
			5'd14: return 12'd4089;
			5'd15: return 12'd4091;
			5'd16: return 12'd4093;
			default: return 12'd4093;
		endcase
	endfunction
endpackage

// ===== src/mba_if.sv =====
// ----------------------------------------------------------------------------
// mba_in_if / mba_out_if / mba_cfg_if
// Valid/ready channels of the fused matrix multiply block.
// ----------------------------------------------------------------------------
interface mba_in_if;
	import mba_pkg::*;
	logic valid;
	logic ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mba_out_if;
	import mba_pkg::*;
	logic valid;
	logic ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mba_cfg_if;
	import mba_pkg::*;
	logic valid;
	logic ready;
	cfg_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/mba_ram.sv =====
// ----------------------------------------------------------------------------
// mba_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module mba_ram #(
	parameter int Width = 16,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ===== src/matmul_bias_activation.sv =====
// ----------------------------------------------------------------------------
// matmul_bias_activation
// Fused matrix multiply, column bias and an optional ReLU or GELU activation.
// ----------------------------------------------------------------------------
// Write requests fill A, B and the bias store, and writes can follow back to
// back. A query runs the bias step and the dot product with rounding, then the
// GELU epilogue when GELU is selected, then saturates and presents the result.
// Its length is set by the one shared 32x32 multiplier, which serves each
// product of the dot product in turn and then every product of the GELU
// polynomial, fed from single-port A and B memories one element per cycle.
// A range error goes from the bias step straight to saturation, without the
// dot product or the activation. The block takes one request at a time; a
// finished result waits in the output register until it is taken, and the
// next request is accepted then.
`include "matmul_bias_activation_macros.svh"
module matmul_bias_activation (
	input logic clk,
	input logic arst_n,
	mba_cfg_if.sink cfg,
	mba_in_if.sink  in_ch,
	mba_out_if.source out_ch
);
	import mba_pkg::*;

	state_t state_q, state_d;
	logic [4:0] m_rows_q, n_cols_q, k_depth_q;
	logic [1:0] act_mode_q;
	logic [3:0] row_q, col_q;
	logic [4:0] k_q;
	logic [4:0] kd_lim;
	logic signed [47:0] acc_q;
	logic signed [31:0] x_q, xc_q, t1_q, mul_a, mul_b;
	logic signed [63:0] prod;
	logic signed [31:0] y_q;
	logic rerr_q;
	out_item_t out_q;
	logic out_valid_q;

	// Memories.
	logic a_we, b_we;
	logic [7:0] a_addr, b_addr;
	logic [15:0] a_rd, b_rd, bias_rd;
	logic signed [15:0] bias_q [MaxCols];
	logic in_acc;

	assign in_acc = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign cfg.ready = 1'b1;

	mba_ram #(.Width(16), .Depth(256)) u_a_ram (
		.clk(clk), .we(a_we), .addr(a_addr), .wdata(in_ch.data.elem_value), .rdata(a_rd));
	mba_ram #(.Width(16), .Depth(256)) u_b_ram (
		.clk(clk), .we(b_we), .addr(b_addr), .wdata(in_ch.data.elem_value), .rdata(b_rd));

	assign a_we = in_acc && (in_ch.data.kind == KIND_WR_A);
	assign b_we = in_acc && (in_ch.data.kind == KIND_WR_B);
	// During the dot product A is read along row i and B down column j.
	always_comb begin
		if (state_q == ST_IDLE) begin
			a_addr = {in_ch.data.row_index, in_ch.data.col_index};
			b_addr = {in_ch.data.row_index, in_ch.data.col_index};
		end else begin
			a_addr = {row_q, k_q[3:0]};
			b_addr = {k_q[3:0], col_q};
		end
	end
	assign bias_rd = bias_q[col_q];

	always_ff @(posedge clk) begin
		if (in_acc && in_ch.data.kind == KIND_WR_BIAS) begin
			bias_q[in_ch.data.col_index] <= in_ch.data.elem_value;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_rows_q <= 5'(MaxRows);
			n_cols_q <= 5'(MaxCols);
			k_depth_q <= 5'(MaxDepth);
			act_mode_q <= ACT_GELU;
		end else if (cfg.valid) begin
			if (cfg.data.cfg_index == 6'(REG_M_ROWS)) m_rows_q <= cfg.data.cfg_value[4:0];
			if (cfg.data.cfg_index == 6'(REG_N_COLS)) n_cols_q <= cfg.data.cfg_value[4:0];
			if (cfg.data.cfg_index == 6'(REG_K_DEPTH)) k_depth_q <= cfg.data.cfg_value[4:0];
			if (cfg.data.cfg_index == 6'(REG_ACT_MODE)) act_mode_q <= cfg.data.cfg_value[1:0];
		end
	end

	assign kd_lim = (k_depth_q > 5'(MaxDepth)) ? 5'(MaxDepth) : k_depth_q;

	// Round half up of a product, with x>>s and a carry from bit s-1.
	function automatic logic signed [31:0] rnd(input logic signed [63:0] v, input int s);
		logic signed [63:0] r;
		r = (v + (64'sd1 <<< (s - 1))) >>> s;
		return r[31:0];
	endfunction

	// Tanh by table lookup and interpolation on |u| in Q.12.
	logic signed [31:0] tanh_v;
	always_comb begin
		logic [31:0] a;
		logic [4:0] idx;
		logic [9:0] fr;
		logic [11:0] t0, t1;
		logic [21:0] p;
		logic [11:0] tv;
		a = t1_q[31] ? 32'(-t1_q) : 32'(t1_q);
		idx = a[14:10];
		fr = a[9:0];
		t0 = tanh_tab(idx);
		t1 = tanh_tab(idx + 5'd1);
		p = 22'(t1 - t0) * 22'(fr) + 22'd512;
		tv = t0 + 12'(p[21:10]);
		if (a >= 32'd16384) begin
			tanh_v = 32'sd4096;
		end else begin
			tanh_v = 32'(tv);
		end
		if (t1_q[31]) tanh_v = -tanh_v;
	end

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = 32'sd0;
		mul_b = 32'sd0;
		case (state_q)
			ST_MAC: begin
				mul_a = 32'(signed'(a_rd));
				mul_b = 32'(signed'(b_rd));
			end
			ST_SQ: begin
				mul_a = xc_q;
				mul_b = xc_q;
			end
			ST_CUBE: begin
				mul_a = t1_q;
				mul_b = xc_q;
			end
			ST_INNER: begin
				mul_a = t1_q;
				mul_b = 32'sd2930;
			end
			ST_U: begin
				mul_a = t1_q;
				mul_b = 32'sd3268;
			end
			ST_OUT: begin
				mul_a = x_q;
				mul_b = 32'sd4096 + t1_q;
			end
			default: begin
			end
		endcase
	end
	assign prod = mul_a * mul_b;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && in_ch.data.kind == KIND_QUERY) state_d = ST_BIAS;
			end
			ST_BIAS: state_d = rerr_q ? ST_SAT : (kd_lim == 5'd0 ? ST_ROUND : ST_MAC);
			ST_MAC: state_d = (k_q == kd_lim) ? ST_ROUND : ST_MAC;
			ST_ROUND: state_d = (act_mode_q == ACT_GELU) ? ST_SQ : ST_SAT;
			ST_SQ: state_d = ST_CUBE;
			ST_CUBE: state_d = ST_INNER;
			ST_INNER: state_d = ST_U;
			ST_U: state_d = ST_TANH;
			ST_TANH: state_d = ST_OUT;
			ST_OUT: state_d = ST_SAT;
			ST_SAT: state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				row_q <= in_ch.data.row_index;
				col_q <= in_ch.data.col_index;
				rerr_q <= (5'(in_ch.data.row_index) >= m_rows_q)
					|| (5'(in_ch.data.col_index) >= n_cols_q);
				k_q <= 5'd0;
			end
			ST_BIAS: begin
				acc_q <= 48'(signed'(bias_rd)) <<< 12;
				k_q <= 5'd1;
			end
			ST_MAC: begin
				// Read data for element k-1 is present this cycle.
				acc_q <= acc_q + 48'(prod);
				k_q <= k_q + 5'd1;
			end
			ST_ROUND: begin
				x_q <= 32'((acc_q + 48'sd2048) >>> 12);
				y_q <= 32'((acc_q + 48'sd2048) >>> 12);
				if (act_mode_q == ACT_RELU && acc_q + 48'sd2048 < 48'sd4096) y_q <= 32'sd0;
				xc_q <= 32'((acc_q + 48'sd2048) >>> 12);
				if (((acc_q + 48'sd2048) >>> 12) > 48'sd16384) xc_q <= 32'sd16384;
				if (((acc_q + 48'sd2048) >>> 12) < -48'sd16384) xc_q <= -32'sd16384;
			end
			ST_SQ: t1_q <= rnd(prod, 12);
			ST_CUBE: t1_q <= rnd(prod, 12);
			ST_INNER: t1_q <= xc_q + rnd(prod, 16);
			ST_U: t1_q <= rnd(prod, 12);
			ST_TANH: t1_q <= tanh_v;
			ST_OUT: y_q <= rnd(prod, 13);
			ST_SAT: begin
				out_q.out_row <= row_q;
				out_q.out_col <= col_q;
				out_q.range_error <= rerr_q;
				if (rerr_q) begin
					out_q.out_value <= 16'sd0;
					out_q.saturated <= 1'b0;
				end else if (y_q > 32'sd32767) begin
					out_q.out_value <= 16'sd32767;
					out_q.saturated <= 1'b1;
				end else if (y_q < -32'sd32768) begin
					out_q.out_value <= -16'sd32768;
					out_q.saturated <= 1'b1;
				end else begin
					out_q.out_value <= y_q[15:0];
					out_q.saturated <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;

	`MBA_ASSERT_IMP(a_busy_not_ready, state_q != ST_IDLE, !in_ch.ready)
	`MBA_ASSERT_NXT(a_done_valid, state_q == ST_DONE, out_valid_q)
	`MBA_ASSERT_IMP(a_mac_bound, state_q == ST_MAC, k_q <= kd_lim && k_q != 5'd0)
endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fused matrix multiply, bias and activation block.
// It fills A, B and the bias store, then walks through several size and
// activation settings. Each setting gets a burst of random writes and queries.
// A scoreboard keeps its own copy of the stores and computes every result.
// Both sides of the block insert random gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
import mba_pkg::*;

// Scoreboard: mirrors the stores and the size registers, predicts each query
// result, and checks returned results against the oldest pending prediction.
class gemm_scoreboard;
	logic signed [15:0] a_store[16][16];
	logic signed [15:0] b_store[16][16];
	logic signed [15:0] bias_store[16];
	logic [4:0] m_rows = 5'd16;
	logic [4:0] n_cols = 5'd16;
	logic [4:0] k_depth = 5'd16;
	logic [1:0] act_mode = ACT_GELU;
	out_item_t pending_results[$];
	int mismatches = 0;

	// The 17 knots of the tanh curve in Q.12, at steps of 0.25 from 0 to 4.
	static const int tanh_knots[17] = '{0, 1003, 1893, 2602, 3119, 3475, 3707,
		3856, 3949, 4006, 4041, 4062, 4076, 4084, 4089, 4091, 4093};

	// Round half up while dropping s fraction bits.
	static function longint round_shift(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	// Clamp a size register to the physical size of its store.
	static function int clamp_size(logic [4:0] v);
		return (v > 16) ? 16 : int'(v);
	endfunction

	// Piecewise-linear tanh in Q.12, with odd symmetry.
	static function longint tanh_pwl(longint u);
		longint mag, t;
		int seg;
		mag = (u < 0) ? -u : u;
		if (mag >= 16384) begin
			t = 4096;
		end else begin
			seg = int'(mag >>> 10);
			t = tanh_knots[seg] + round_shift(longint'(tanh_knots[seg + 1] -
				tanh_knots[seg]) * (mag & 1023), 10);
		end
		return (u < 0) ? -t : t;
	endfunction

	// GELU in its tanh form, built from Q.12 fixed-point steps.
	static function longint gelu_fixed(longint x);
		longint xc, sq, cube, inner, u;
		xc = (x > 16384) ? 16384 : ((x < -16384) ? -16384 : x);
		sq = round_shift(xc * xc, 12);
		cube = round_shift(sq * xc, 12);
		inner = xc + round_shift(cube * 2930, 16);
		u = round_shift(inner * 3268, 12);
		return round_shift(x * (4096 + tanh_pwl(u)), 13);
	endfunction

	function void write_register(reg_idx_t idx, logic [31:0] value);
		case (idx)
			REG_M_ROWS:   m_rows = value[4:0];
			REG_N_COLS:   n_cols = value[4:0];
			REG_K_DEPTH:  k_depth = value[4:0];
			REG_ACT_MODE: act_mode = value[1:0];
		endcase
	endfunction

	// Called for each accepted request: a write updates the mirror, a query
	// pushes its predicted result.
	function void note_request(in_item_t req);
		out_item_t res;
		longint acc, x, y;
		case (kind_t'(req.kind))
			KIND_WR_A:    a_store[req.row_index][req.col_index] = req.elem_value;
			KIND_WR_B:    b_store[req.row_index][req.col_index] = req.elem_value;
			KIND_WR_BIAS: bias_store[req.col_index] = req.elem_value;
			KIND_QUERY: begin
				res.out_row = req.row_index;
				res.out_col = req.col_index;
				res.out_value = '0;
				res.saturated = 1'b0;
				res.range_error = 1'b0;
				if (req.row_index >= clamp_size(m_rows) ||
				    req.col_index >= clamp_size(n_cols)) begin
					res.range_error = 1'b1;
				end else begin
					acc = 0;
					for (int k = 0; k < clamp_size(k_depth); k++)
						acc += longint'(a_store[req.row_index][k]) *
							longint'(b_store[k][req.col_index]);
					acc += longint'(bias_store[req.col_index]) <<< 12;
					x = round_shift(acc, 12);
					if (act_mode == ACT_RELU)
						y = (x > 0) ? x : 0;
					else if (act_mode == ACT_GELU)
						y = gelu_fixed(x);
					else
						y = x;
					if (y > 32767) begin
						y = 32767;
						res.saturated = 1'b1;
					end else if (y < -32768) begin
						y = -32768;
						res.saturated = 1'b1;
					end
					res.out_value = y[15:0];
				end
				pending_results.push_back(res);
			end
		endcase
	endfunction

	function void check_result(out_item_t got);
		out_item_t want;
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: row %0d col %0d value %0d",
					got.out_row, got.out_col, got.out_value);
			return;
		end
		want = pending_results.pop_front();
		if (got.out_row !== want.out_row || got.out_col !== want.out_col ||
		    got.out_value !== want.out_value || got.saturated !== want.saturated ||
		    got.range_error !== want.range_error) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected r%0d c%0d v%0d sat%0d err%0d, got r%0d c%0d v%0d sat%0d err%0d",
					want.out_row, want.out_col, want.out_value, want.saturated,
					want.range_error, got.out_row, got.out_col, got.out_value,
					got.saturated, got.range_error);
		end
	endfunction
endclass

module testbench;
	// Cycles without any accepted transfer before the run is declared hung.
	localparam int StallLimit = 5000;
	// Settling time after the last result, above the slowest query latency.
	localparam int DrainCycles = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mba_cfg_if cfg_ch();
	mba_in_if in_ch();
	mba_out_if out_ch();

	matmul_bias_activation u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	gemm_scoreboard sb = new();

	// When low, both sides run without gaps, so back-to-back traffic is covered.
	bit gaps_on = 1'b1;
	int out_hold = 0;
	int quiet_cycles = 0;

	always #1 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int p;
		p = $urandom_range(99);
		if (p < 80)
			return $urandom_range(3, 1);
		else if (p < 95)
			return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	// Element values: full range, the small range where GELU bends, and the
	// corner values of Q4.12.
	function automatic logic signed [15:0] pick_value();
		int p;
		logic signed [15:0] corners[5] = '{16'sh8000, 16'sh7FFF, 16'sh0000,
			16'shFFFF, 16'sh0001};
		p = $urandom_range(99);
		if (p < 40)
			return 16'($urandom());
		else if (p < 80)
			return 16'(int'($urandom_range(1200)) - 600);
		return corners[$urandom_range(4)];
	endfunction

	// The result channel's ready is chosen at each falling edge.
	always @(negedge clk) begin
		if (out_hold > 0) begin
			out_ch.ready <= 1'b0;
			out_hold <= out_hold - 1;
		end else if (gaps_on && $urandom_range(99) < 25) begin
			out_ch.ready <= 1'b0;
			out_hold <= pick_gap() - 1;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Results are taken and checked at the rising edge.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result(out_ch.data);
	end

	// Watchdog: any accepted transfer on any channel counts as progress.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
		    (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= StallLimit) begin
				$display("testbench NOT OK");
				$finish;
			end
		end
	end

	// Present one request, after an optional gap, and wait until it is taken.
	// Valid stays high into the next request when no gap follows.
	task automatic send_request(kind_t kind, int row, int col, logic signed [15:0] value);
		in_item_t req;
		int gap;
		req.kind = kind;
		req.row_index = row[3:0];
		req.col_index = col[3:0];
		req.elem_value = value;
		gap = (gaps_on && $urandom_range(99) < 30) ? pick_gap() : 0;
		repeat (gap) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.data <= req;
		do
			@(posedge clk);
		while (!in_ch.ready);
		sb.note_request(req);
	endtask

	task automatic wait_until_drained();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Register writes only happen once the block has gone quiet.
	task automatic write_register(reg_idx_t idx, int value);
		cfg_item_t w;
		w.cfg_index = {4'd0, idx};
		w.cfg_value = {27'($urandom()), value[4:0]};
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= w;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		sb.write_register(idx, w.cfg_value);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_sizes(int m, int n, int k, int act);
		wait_until_drained();
		write_register(REG_M_ROWS, m);
		write_register(REG_N_COLS, n);
		write_register(REG_K_DEPTH, k);
		write_register(REG_ACT_MODE, act);
	endtask

	// Random traffic: mostly in-range queries, some queries anywhere, and
	// overwrites of stored elements with fresh values.
	task automatic random_traffic(int count);
		int p, m, n;
		m = (sb.m_rows > 16) ? 16 : sb.m_rows;
		n = (sb.n_cols > 16) ? 16 : sb.n_cols;
		for (int i = 0; i < count; i++) begin
			p = $urandom_range(99);
			if (p < 60 && m > 0 && n > 0)
				send_request(KIND_QUERY, $urandom_range(m - 1), $urandom_range(n - 1),
					16'($urandom()));
			else if (p < 75)
				send_request(KIND_QUERY, $urandom_range(15), $urandom_range(15),
					16'($urandom()));
			else if (p < 85)
				send_request(KIND_WR_A, $urandom_range(15), $urandom_range(15),
					pick_value());
			else if (p < 95)
				send_request(KIND_WR_B, $urandom_range(15), $urandom_range(15),
					pick_value());
			else
				send_request(KIND_WR_BIAS, $urandom_range(15), $urandom_range(15),
					pick_value());
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		out_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Fill every entry of every store first, so no query ever reads an
		// entry that was never written.
		for (int r = 0; r < 16; r++)
			for (int c = 0; c < 16; c++) begin
				send_request(KIND_WR_A, r, c, pick_value());
				send_request(KIND_WR_B, r, c, pick_value());
			end
		for (int c = 0; c < 16; c++)
			send_request(KIND_WR_BIAS, $urandom_range(15), c, pick_value());

		// Reset settings: full sizes with GELU.
		random_traffic(60);

		// Directed corners with a one-term dot product and no activation: the
		// largest products saturate both ways, and the bias extremes add in.
		set_sizes(16, 16, 1, ACT_NONE);
		send_request(KIND_WR_A, 0, 0, 16'sh8000);
		send_request(KIND_WR_B, 0, 0, 16'sh8000);
		send_request(KIND_WR_BIAS, 0, 0, 16'sh7FFF);
		send_request(KIND_WR_A, 15, 0, 16'sh7FFF);
		send_request(KIND_WR_B, 0, 15, 16'sh8000);
		send_request(KIND_WR_BIAS, 15, 15, 16'sh8000);
		send_request(KIND_QUERY, 0, 0, 16'sh0000);
		send_request(KIND_QUERY, 15, 15, 16'shFFFF);
		send_request(KIND_QUERY, 0, 15, 16'sh0000);
		send_request(KIND_QUERY, 15, 0, 16'shFFFF);
		random_traffic(50);

		// Small matrix with ReLU; many queries land out of range.
		set_sizes(4, 5, 3, ACT_RELU);
		random_traffic(70);

		// One row, one column, full depth, GELU, in a stretch with no gaps.
		gaps_on = 1'b0;
		set_sizes(1, 1, 16, ACT_GELU);
		random_traffic(60);
		gaps_on = 1'b1;

		// Registers above the store sizes act as full size; code three is no
		// activation.
		set_sizes(31, 31, 31, 3);
		random_traffic(70);

		// Zero rows makes every query a range error; zero depth is an empty sum.
		set_sizes(0, 7, 0, ACT_GELU);
		random_traffic(30);
		set_sizes(9, 16, 0, ACT_GELU);
		random_traffic(40);

		set_sizes(9, 16, 8, ACT_RELU);
		random_traffic(70);

		wait_until_drained();
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule
